// ===== hw/rtl/touch_position_smoother_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Touch position smoother assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef TOUCH_POSITION_SMOOTHER_UNIT_DEFINES_SVH
`define TOUCH_POSITION_SMOOTHER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define TPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TPS_ASSERT_IMPL(name, ante, cons, msg)
`define TPS_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch position smoother package
// Field widths, command and mode codes, register indexes and item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  // coordinate and field widths
  localparam int COORD_W = 20;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int RATIO_W = 16;
  localparam int GAIN_W  = 16;
  localparam int TILT_W  = 16;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 2;

  // step arithmetic: k = gain*|tilt| >> 15, m = |d|*ratio >> 8, mv = m*scale >> 24
  localparam int K_SHIFT = 15;
  localparam int K_W     = 16;
  localparam int M_SHIFT = 8;
  localparam int M_W     = COORD_W + RATIO_W - M_SHIFT;
  localparam int SCALE_W = 17;
  localparam int V_SHIFT = 24;
  localparam int MV_W    = M_W + SCALE_W - V_SHIFT;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << 16;

  // serial multiplier operand widths
  localparam int MUL_A_W = M_W;
  localparam int MUL_B_W = COORD_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // command codes
  localparam logic [1:0] CMD_SET     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_INTERP  = 2'd1;
  localparam logic [1:0] MODE_MATCHED = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_STEP_RATIO = 2'd0;
  localparam logic [IDX_W-1:0] REG_FORCE_GAIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_NEAR_THR   = 2'd2;

  // register reset values
  localparam logic [RATIO_W-1:0] RATIO_RST  = 16'd13107;
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd6554;
  localparam logic [COORD_W-1:0] THRESH_RST = 20'd256;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [COORD_W-1:0]        new_x;
    logic [COORD_W-1:0]        new_y;
    logic [COORD_W-1:0]        goal_x;
    logic [COORD_W-1:0]        goal_y;
    logic signed [TILT_W-1:0]  tilt_x;
    logic signed [TILT_W-1:0]  tilt_y;
  } tps_cmd_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] smooth_x;
    logic [COORD_W-1:0] smooth_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
  } tps_res_t;

  typedef struct packed {
    logic [RATIO_W-1:0] step_ratio;
    logic [GAIN_W-1:0]  force_gain;
    logic [COORD_W-1:0] near_threshold;
  } tps_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tps_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Touch position smoother serial multiplier
// Shift-add unsigned multiplier, one multiplier bit per cycle, stops early
// once the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_serial_mul (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire [tps_pkg::MUL_A_W-1:0]    a_in,
  input  wire [tps_pkg::MUL_B_W-1:0]    b_in,
  output logic                          busy,
  output logic [tps_pkg::MUL_P_W-1:0]   prod
);
  import tps_pkg::*;

  logic [MUL_P_W-1:0] mcand;
  logic [MUL_B_W-1:0] mplier;

  // busy flag: runs while multiplier bits remain
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= |b_in;
    end else if (busy) begin
      busy <= |mplier[MUL_B_W-1:1];
    end
  end

  // operand shifters and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= MUL_P_W'(a_in);
      mplier <= b_in;
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tps_engine.sv =====
// ----------------------------------------------------------------------------
// Touch position smoother engine
// Holds touch point, smoothed point and mode; sequences the per-axis step and
// the nearness test through one shared serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_engine (
  input  wire                   clk,
  input  wire                   rst,
  input  tps_pkg::tps_cfg_t     cfg,
  input  wire                   start,
  input  tps_pkg::tps_cmd_t     item,
  output logic                  ready,
  output logic                  res_valid,
  input  wire                   res_take,
  output tps_pkg::tps_res_t     res
);
  import tps_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MV_K  = 4'd1;
  localparam logic [3:0] S_MV_KW = 4'd2;
  localparam logic [3:0] S_MV_MW = 4'd3;
  localparam logic [3:0] S_MV_VW = 4'd4;
  localparam logic [3:0] S_NR_X  = 4'd5;
  localparam logic [3:0] S_NR_XW = 4'd6;
  localparam logic [3:0] S_NR_YW = 4'd7;
  localparam logic [3:0] S_NR_TW = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]          state;
  logic [1:0]          phase;
  logic [COORD_W-1:0]  touch_x, touch_y, filt_x, filt_y, tgt_x, tgt_y;
  logic [TILT_W-1:0]   tilt_x, tilt_y;
  logic                axis, is_tick, near_flag, d_neg, same;
  logic [COORD_W-1:0]  dm;
  logic [SCALE_W-1:0]  scale;
  logic [2*COORD_W:0]  sq_sum;

  logic                mul_start, mul_busy;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_prod;
  logic                mul_done;

  // current axis operands
  logic [COORD_W-1:0]  cur_pos, cur_tgt;
  logic [TILT_W-1:0]   cur_tilt, tilt_mag;
  logic [DIFF_W-1:0]   diff, diff_abs;
  logic                diff_neg, tilt_neg, tilt_pos, same_next;
  logic [K_W-1:0]      k_val;
  logic [SCALE_W-1:0]  scale_next;
  logic [M_W-1:0]      m_val;
  logic [MV_W-1:0]     mv_val;
  logic [COORD_W+1:0]  up_sum;
  logic [COORD_W-1:0]  up_pos, dn_pos, new_pos;

  // nearness operands
  logic [DIFF_W-1:0]   ddx, ddy;
  logic [COORD_W-1:0]  dx, dy;
  logic                far;

  tps_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  assign mul_done = !mul_busy;

  // axis step datapath
  always_comb begin
    cur_pos   = axis ? filt_y : filt_x;
    cur_tgt   = axis ? tgt_y  : tgt_x;
    cur_tilt  = axis ? tilt_y : tilt_x;
    diff      = {1'b0, cur_tgt} - {1'b0, cur_pos};
    diff_neg  = diff[DIFF_W-1];
    diff_abs  = diff_neg ? (~diff + 1'b1) : diff;
    tilt_neg  = cur_tilt[TILT_W-1];
    tilt_mag  = tilt_neg ? (~cur_tilt + 1'b1) : cur_tilt;
    tilt_pos  = !tilt_neg && (|cur_tilt);
    same_next = (!diff_neg && (|diff) && tilt_pos) || (diff_neg && tilt_neg);
    k_val      = mul_prod[K_SHIFT +: K_W];
    scale_next = same ? (SCALE_ONE + SCALE_W'(k_val)) : (SCALE_ONE - SCALE_W'(k_val));
    m_val      = mul_prod[M_SHIFT +: M_W];
    mv_val     = mul_prod[V_SHIFT +: MV_W];
    // saturate at both ends of the coordinate range
    up_sum = {2'b00, cur_pos} + (COORD_W+2)'(mv_val);
    up_pos = (|up_sum[COORD_W+1:COORD_W]) ? {COORD_W{1'b1}} : up_sum[COORD_W-1:0];
    dn_pos = (mv_val > MV_W'(cur_pos)) ? '0 : (cur_pos - mv_val[COORD_W-1:0]);
    new_pos = d_neg ? dn_pos : up_pos;
  end

  // distance per axis against the target
  always_comb begin
    ddx = {1'b0, tgt_x} - {1'b0, filt_x};
    ddy = {1'b0, tgt_y} - {1'b0, filt_y};
    dx  = ddx[DIFF_W-1] ? COORD_W'(~ddx + 1'b1) : ddx[COORD_W-1:0];
    dy  = ddy[DIFF_W-1] ? COORD_W'(~ddy + 1'b1) : ddy[COORD_W-1:0];
    far = (dx >= cfg.near_threshold) || (dy >= cfg.near_threshold);
  end

  // multiplier launches
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_MV_K: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(cfg.force_gain);
        mul_b     = MUL_B_W'(tilt_mag);
      end
      S_MV_KW: begin
        mul_start = mul_done;
        mul_a     = MUL_A_W'(dm);
        mul_b     = MUL_B_W'(cfg.step_ratio);
      end
      S_MV_MW: begin
        mul_start = mul_done;
        mul_a     = m_val;
        mul_b     = MUL_B_W'(scale);
      end
      S_NR_X: begin
        mul_start = !far;
        mul_a     = MUL_A_W'(dx);
        mul_b     = dx;
      end
      S_NR_XW: begin
        mul_start = mul_done;
        mul_a     = MUL_A_W'(dy);
        mul_b     = dy;
      end
      S_NR_YW: begin
        mul_start = mul_done;
        mul_a     = MUL_A_W'(cfg.near_threshold);
        mul_b     = cfg.near_threshold;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= MODE_OFF;
      touch_x <= '0;
      touch_y <= '0;
      filt_x  <= '0;
      filt_y  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (item.cmd)
              CMD_SET: begin
                touch_x <= item.new_x;
                touch_y <= item.new_y;
                tgt_x   <= item.new_x;
                tgt_y   <= item.new_y;
                is_tick <= 1'b0;
                state   <= S_NR_X;
              end
              CMD_RELEASE: begin
                phase <= MODE_RELEASE;
                state <= S_DONE;
              end
              CMD_TICK: begin
                if (phase == MODE_INTERP || phase == MODE_RELEASE) begin
                  tgt_x   <= (phase == MODE_RELEASE) ? item.goal_x : touch_x;
                  tgt_y   <= (phase == MODE_RELEASE) ? item.goal_y : touch_y;
                  tilt_x  <= item.tilt_x;
                  tilt_y  <= item.tilt_y;
                  axis    <= 1'b0;
                  is_tick <= 1'b1;
                  state   <= S_MV_K;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MV_K: begin
          dm    <= diff_abs[COORD_W-1:0];
          d_neg <= diff_neg;
          same  <= same_next;
          state <= S_MV_KW;
        end
        S_MV_KW: begin
          if (mul_done) begin
            scale <= scale_next;
            state <= S_MV_MW;
          end
        end
        S_MV_MW: begin
          if (mul_done) begin
            state <= S_MV_VW;
          end
        end
        S_MV_VW: begin
          if (mul_done) begin
            if (axis) begin
              filt_y <= new_pos;
              state  <= S_NR_X;
            end else begin
              filt_x <= new_pos;
              axis   <= 1'b1;
              state  <= S_MV_K;
            end
          end
        end
        S_NR_X: begin
          if (far) begin
            near_flag <= 1'b0;
            state     <= S_FIN;
          end else begin
            state <= S_NR_XW;
          end
        end
        S_NR_XW: begin
          if (mul_done) begin
            sq_sum <= mul_prod[2*COORD_W:0];
            state  <= S_NR_YW;
          end
        end
        S_NR_YW: begin
          if (mul_done) begin
            sq_sum <= sq_sum + mul_prod[2*COORD_W:0];
            state  <= S_NR_TW;
          end
        end
        S_NR_TW: begin
          if (mul_done) begin
            near_flag <= sq_sum < mul_prod[2*COORD_W:0];
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          // snap on nearness; a finished release turns the block off
          if (near_flag) begin
            filt_x <= tgt_x;
            filt_y <= tgt_y;
            phase  <= (is_tick && phase == MODE_RELEASE) ? MODE_OFF : MODE_MATCHED;
          end else if (!is_tick) begin
            phase <= MODE_INTERP;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{mode: phase, smooth_x: filt_x, smooth_y: filt_y,
                       target_x: touch_x, target_y: touch_y};

endmodule

`default_nettype wire

// ===== hw/rtl/touch_position_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// Touch position smoother unit
// Smooths a touch point toward its target per tick, with tilt bias and snap.
// ----------------------------------------------------------------------------
// One command item in gives one result item out. A release or an idle tick
// goes straight to the result; a set command runs the nearness test; a moving
// tick runs two axis steps plus the nearness test. All products go through one
// shift-add multiplier that retires one multiplier bit per cycle and stops at
// the last set bit, so small distances and forces finish sooner. The next
// command is taken once the previous result has moved into the output
// register, which can wait for the consumer independently.
`default_nettype none

`include "touch_position_smoother_unit_defines.svh"

module touch_position_smoother_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cmd_valid,
  output logic                          cmd_ready,
  input  tps_pkg::tps_cmd_t             cmd_item,
  output logic                          res_valid,
  input  wire                           res_ready,
  output tps_pkg::tps_res_t             res_item,
  input  wire                           cfg_write,
  input  wire [tps_pkg::IDX_W-1:0]      cfg_index,
  input  wire [tps_pkg::CFG_W-1:0]      cfg_data
);
  import tps_pkg::*;

  tps_cfg_t  cfg;
  tps_res_t  eng_res;
  logic      eng_ready, eng_res_valid, res_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_ratio     <= RATIO_RST;
      cfg.force_gain     <= GAIN_RST;
      cfg.near_threshold <= THRESH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_RATIO: cfg.step_ratio     <= cfg_data[RATIO_W-1:0];
        REG_FORCE_GAIN: cfg.force_gain     <= cfg_data[GAIN_W-1:0];
        REG_NEAR_THR:   cfg.near_threshold <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  tps_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (cmd_valid && cmd_ready),
    .item      (cmd_item),
    .ready     (eng_ready),
    .res_valid (eng_res_valid),
    .res_take  (res_load),
    .res       (eng_res)
  );

  assign cmd_ready = eng_ready;

  // output register: loads when empty or being drained
  assign res_load = eng_res_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_item <= eng_res;
    end
  end

  // checks
  `TPS_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "engine still ready after taking an item")
  `TPS_ASSERT_NEXT(a_result_held, eng_res_valid && !res_load, eng_res_valid, "pending result dropped")
  `TPS_ASSERT_NEXT(a_result_loaded, res_load, res_valid, "loaded result not presented")
  `TPS_ASSERT_IMPL(a_no_accept_pending, eng_res_valid, !cmd_ready, "item taken while a result is pending")

endmodule

`default_nettype wire
